### src/rpc_pkg.sv
// Shared constants and register codes for the penalty contact law block.
package rpc_pkg;

  // Default saturation width of the results
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed widths of the transaction fields and the configuration port
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFFNESS = 2'd0,
    REG_REG_GAP   = 2'd1,
    REG_FRICTION  = 2'd2
  } cfg_idx_e;

endpackage

### src/rpc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
module rpc_div #(
  parameter int unsigned NUM_W  = 62,
  parameter int unsigned DEN_W  = 31,
  parameter int unsigned QUO_W  = 31,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,   // held steady while transactions are in flight
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  // Caller guarantees num_i >> QUO_W < den_i, so the head fits the remainder
  localparam int unsigned HEAD_W = NUM_W - QUO_W;

  logic              vld_q  [QUO_W];
  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  logic              vld_in  [QUO_W];
  logic [DEN_W-1:0]  rem_in  [QUO_W];
  logic [QUO_W-1:0]  quo_in  [QUO_W];
  logic [SIDE_W-1:0] side_in [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_d;
    logic [QUO_W-1:0] quo_d;

    // Stage input: the dividend head enters the first stage
    if (j == 0) begin : g_first
      assign vld_in[j]  = valid_i;
      assign rem_in[j]  = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign quo_in[j]  = num_i[QUO_W-1:0];
      assign side_in[j] = side_i;
    end else begin : g_next
      assign vld_in[j]  = vld_q[j-1];
      assign rem_in[j]  = rem_q[j-1];
      assign quo_in[j]  = quo_q[j-1];
      assign side_in[j] = side_q[j-1];
    end

    // Shift in one dividend bit, subtract if it fits
    assign trial = {rem_in[j], quo_in[j][QUO_W-1]};
    assign ge    = trial >= {1'b0, den_i};
    assign diff  = ge ? (trial - {1'b0, den_i}) : trial;
    assign rem_d = diff[DEN_W-1:0];
    assign quo_d = {quo_in[j][QUO_W-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        quo_q[j]  <= quo_d;
        side_q[j] <= side_in[j];
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

### src/regularized_penalty_contact_law.sv
// Top level: pipelined regularized penalty contact law with friction limit.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------------------
//   in       | in_valid_i / in_ready_o | contact_gap_i, force_correction_i,
//            |                         | normal_force_i
//   out      | out_valid_o/out_ready_i | contact_force_o, force_slope_o,
//            |                         | friction_limit_o, gap_correction_o
//   config   | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One transaction per cycle while the output is not stalled. Stages in order: input stage,
// 31-stage divider for the quadratic slope, 3 stages, 62-stage divider for the law
// inversion, 1 stage, 31-stage square root, output register.
// Reset clears the stiffness, gap and friction registers and all valid bits.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module regularized_penalty_contact_law #(
  parameter int unsigned DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rpc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rpc_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [rpc_pkg::FIELD_W-1:0]  contact_gap_i,
  input  logic signed [rpc_pkg::FIELD_W-1:0]  force_correction_i,
  input  logic signed [rpc_pkg::FIELD_W-1:0]  normal_force_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rpc_pkg::FIELD_W-1:0]  contact_force_o,
  output logic signed [rpc_pkg::FIELD_W-1:0]  force_slope_o,
  output logic signed [rpc_pkg::FIELD_W-1:0]  friction_limit_o,
  output logic signed [rpc_pkg::FIELD_W-1:0]  gap_correction_o
);

  localparam int unsigned SAT_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
  localparam int unsigned SQ_N = 31;

  typedef struct packed {
    logic signed [31:0] gap;
    logic signed [31:0] corr;
    logic               lin;
    logic               pos;
    logic signed [31:0] fric;
    logic signed [31:0] flin;
  } d1_side_t;

  typedef struct packed {
    logic signed [31:0] gap;
    logic signed [31:0] fric;
    logic signed [31:0] force_v;
    logic signed [31:0] slope;
    logic               act;
    logic               use_lin;
  } d2_side_t;

  typedef struct packed {
    d2_side_t    base;
    logic [48:0] gap_lin;
  } sq_side_t;

  // Saturate to the signed output range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[31:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [30:0] k_q, gb_q, mu_q;
  logic [61:0] kg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      gb_q <= '0;
      mu_q <= '0;
    end else if (cfg_we_i) begin
      case (rpc_pkg::cfg_idx_e'(cfg_idx_i))
        rpc_pkg::REG_STIFFNESS: k_q  <= cfg_data_i;
        rpc_pkg::REG_REG_GAP:   gb_q <= cfg_data_i;
        rpc_pkg::REG_FRICTION:  mu_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // k*gb follows the registers; settled long before any item needs it
  always_ff @(posedge clk_i) begin
    kg_q <= 62'(k_q) * 62'(gb_q);
  end

  // Global advance: move when the output register is empty or being taken
  logic adv;
  logic out_vld_q;
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Stage A: branch decision, force product, friction product
  logic        lin_d, pos_d;
  logic [32:0] span_d, mop_d;
  logic [31:0] nmag_d;
  logic [63:0] prod_d;
  logic [62:0] fprod_d;

  assign lin_d  = $signed({contact_gap_i[31], contact_gap_i}) > $signed({2'b00, gb_q});
  assign pos_d  = !contact_gap_i[31] && (contact_gap_i != '0);
  assign span_d = {contact_gap_i, 1'b0} - {2'b00, gb_q};
  assign mop_d  = lin_d ? span_d : {1'b0, contact_gap_i};
  assign prod_d = 64'(k_q) * 64'(mop_d);
  assign nmag_d = normal_force_i[31] ? 32'(-normal_force_i) : normal_force_i;
  assign fprod_d = 63'(mu_q) * 63'(nmag_d);

  logic               a_vld_q;
  logic signed [31:0] a_gap_q, a_corr_q;
  logic [63:0]        a_prod_q;
  logic [62:0]        a_fprod_q;
  logic               a_nneg_q, a_lin_q, a_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_gap_q   <= contact_gap_i;
      a_corr_q  <= force_correction_i;
      a_prod_q  <= prod_d;
      a_fprod_q <= fprod_d;
      a_nneg_q  <= normal_force_i[31];
      a_lin_q   <= lin_d;
      a_pos_q   <= pos_d;
    end
  end

  // Friction and linear force finish here; quadratic slope goes to the divider
  d1_side_t d1_in;
  logic signed [63:0] fmag;

  assign fmag          = $signed({17'b0, a_fprod_q[62:16]});
  assign d1_in.gap     = a_gap_q;
  assign d1_in.corr    = a_corr_q;
  assign d1_in.lin     = a_lin_q;
  assign d1_in.pos     = a_pos_q;
  assign d1_in.fric    = a_nneg_q ? sat32(-fmag) : sat32(fmag);
  assign d1_in.flin    = sat32($signed({17'b0, a_prod_q[63:17]}));

  logic                      d1_vld;
  logic [30:0]               d1_quo;
  logic [$bits(d1_side_t)-1:0] d1_side_vec;
  d1_side_t                  d1_out;

  rpc_div #(
    .NUM_W (62),
    .DEN_W (31),
    .QUO_W (31),
    .SIDE_W($bits(d1_side_t))
  ) u_div_slope (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(a_vld_q),
    .num_i  (a_prod_q[61:0]),
    .den_i  (gb_q),
    .side_i (d1_in),
    .valid_o(d1_vld),
    .quo_o  (d1_quo),
    .side_o (d1_side_vec)
  );

  assign d1_out = d1_side_t'(d1_side_vec);

  // Stage C: quadratic force product d*g
  logic        c_vld_q;
  d1_side_t    c_side_q;
  logic [30:0] c_d_q;
  logic [61:0] c_qprod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_side_q  <= d1_out;
      c_d_q     <= d1_quo;
      c_qprod_q <= 62'(d1_quo) * 62'(d1_out.gap[30:0]);
    end
  end

  // Stage D: pick branch, saturate, residual force
  logic signed [31:0] force_d, slope_d;
  logic signed [32:0] resid_d;

  always_comb begin
    if (c_side_q.lin) begin
      force_d = c_side_q.flin;
      slope_d = sat32(64'(k_q));
    end else if (c_side_q.pos) begin
      force_d = sat32($signed({19'b0, c_qprod_q[61:17]}));
      slope_d = sat32(64'(c_d_q));
    end else begin
      force_d = '0;
      slope_d = '0;
    end
  end

  assign resid_d = $signed({force_d[31], force_d}) - $signed({c_side_q.corr[31], c_side_q.corr});

  logic               d_vld_q;
  logic signed [31:0] d_gap_q, d_fric_q, d_force_q, d_slope_q;
  logic signed [32:0] d_resid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (adv) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_gap_q   <= c_side_q.gap;
      d_fric_q  <= c_side_q.fric;
      d_force_q <= force_d;
      d_slope_q <= slope_d;
      d_resid_q <= resid_d;
    end
  end

  // Stage E: choose inversion branch, scale residual
  logic [48:0] num_d;
  logic [61:0] ndiff_d;
  logic        act_d, use_lin_d;

  assign num_d     = {d_resid_q[31:0], 17'b0};
  assign act_d     = (k_q != '0) && !d_resid_q[32] && (d_resid_q != '0);
  assign use_lin_d = 62'(num_d) >= kg_q;
  assign ndiff_d   = 62'(num_d) - kg_q;

  logic               e_vld_q;
  logic signed [31:0] e_gap_q, e_fric_q, e_force_q, e_slope_q;
  logic               e_act_q, e_use_lin_q;
  logic [47:0]        e_diff_q;
  logic [62:0]        e_rg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (adv) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_gap_q     <= d_gap_q;
      e_fric_q    <= d_fric_q;
      e_force_q   <= d_force_q;
      e_slope_q   <= d_slope_q;
      e_act_q     <= act_d;
      e_use_lin_q <= use_lin_d;
      e_diff_q    <= ndiff_d[48:1];
      e_rg_q      <= 63'(d_resid_q[31:0]) * 63'(gb_q);
    end
  end

  // Inversion divider: (N-kg)/2 by k on the linear side, N*gb by k otherwise
  d2_side_t    d2_in;
  logic [79:0] d2_num;

  assign d2_num        = e_use_lin_q ? 80'(e_diff_q) : {e_rg_q[62:0], 17'b0};
  assign d2_in.gap     = e_gap_q;
  assign d2_in.fric    = e_fric_q;
  assign d2_in.force_v = e_force_q;
  assign d2_in.slope   = e_slope_q;
  assign d2_in.act     = e_act_q;
  assign d2_in.use_lin = e_use_lin_q;

  logic                        d2_vld;
  logic [61:0]                 d2_quo;
  logic [$bits(d2_side_t)-1:0] d2_side_vec;

  rpc_div #(
    .NUM_W (80),
    .DEN_W (31),
    .QUO_W (62),
    .SIDE_W($bits(d2_side_t))
  ) u_div_inv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(e_vld_q),
    .num_i  (d2_num),
    .den_i  (k_q),
    .side_i (d2_in),
    .valid_o(d2_vld),
    .quo_o  (d2_quo),
    .side_o (d2_side_vec)
  );

  // Stage F: linear-side gap, radicand for the root
  logic        f_vld_q;
  sq_side_t    f_side_q;
  logic [61:0] f_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (adv) begin
      f_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_side_q.base    <= d2_side_t'(d2_side_vec);
      f_side_q.gap_lin <= 49'(gb_q) + 49'(d2_quo[47:0]);
      f_rad_q          <= d2_quo;
    end
  end

  // Square root: two radicand bits per stage
  logic        sq_vld_q  [SQ_N];
  logic [32:0] sq_rem_q  [SQ_N];
  logic [30:0] sq_root_q [SQ_N];
  logic [61:0] sq_x_q    [SQ_N];
  sq_side_t    sq_side_q [SQ_N];

  logic        sq_vld_in  [SQ_N];
  logic [32:0] sq_rem_in  [SQ_N];
  logic [30:0] sq_root_in [SQ_N];
  logic [61:0] sq_x_in    [SQ_N];
  sq_side_t    sq_side_in [SQ_N];

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    logic [34:0] t;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;

    if (j == 0) begin : g_first
      assign sq_vld_in[j]  = f_vld_q;
      assign sq_rem_in[j]  = '0;
      assign sq_root_in[j] = '0;
      assign sq_x_in[j]    = f_rad_q;
      assign sq_side_in[j] = f_side_q;
    end else begin : g_next
      assign sq_vld_in[j]  = sq_vld_q[j-1];
      assign sq_rem_in[j]  = sq_rem_q[j-1];
      assign sq_root_in[j] = sq_root_q[j-1];
      assign sq_x_in[j]    = sq_x_q[j-1];
      assign sq_side_in[j] = sq_side_q[j-1];
    end

    assign t     = {sq_rem_in[j], sq_x_in[j][61:60]};
    assign trial = {2'b00, sq_root_in[j], 2'b01};
    assign ge    = t >= trial;
    assign diff  = ge ? (t - trial) : t;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[j] <= sq_vld_in[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[j]  <= diff[32:0];
        sq_root_q[j] <= {sq_root_in[j][29:0], ge};
        sq_x_q[j]    <= {sq_x_in[j][59:0], 2'b00};
        sq_side_q[j] <= sq_side_in[j];
      end
    end
  end

  // Final gap correction and output register
  sq_side_t           last_side;
  logic signed [63:0] gap_new;
  logic signed [63:0] gc_full;

  assign last_side = sq_side_q[SQ_N-1];

  always_comb begin
    if (!last_side.base.act) begin
      gap_new = '0;
    end else if (last_side.base.use_lin) begin
      gap_new = 64'(last_side.gap_lin);
    end else begin
      gap_new = 64'(sq_root_q[SQ_N-1]);
    end
  end

  assign gc_full = {{32{last_side.base.gap[31]}}, last_side.base.gap} - gap_new;

  logic signed [31:0] out_force_q, out_slope_q, out_fric_q, out_gc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= sq_vld_q[SQ_N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_force_q <= last_side.base.force_v;
      out_slope_q <= last_side.base.slope;
      out_fric_q  <= last_side.base.fric;
      out_gc_q    <= sat32(gc_full);
    end
  end

  assign out_valid_o      = out_vld_q;
  assign contact_force_o  = out_force_q;
  assign force_slope_o    = out_slope_q;
  assign friction_limit_o = out_fric_q;
  assign gap_correction_o = out_gc_q;

endmodule

### src/rpc_checker.sv
// Port-level checker for the penalty contact law block, with its bind.
module rpc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_we_i,
  input logic [rpc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input logic [rpc_pkg::CFG_W-1:0]          cfg_data_i,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic signed [rpc_pkg::FIELD_W-1:0] contact_gap_i,
  input logic signed [rpc_pkg::FIELD_W-1:0] force_correction_i,
  input logic signed [rpc_pkg::FIELD_W-1:0] normal_force_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [rpc_pkg::FIELD_W-1:0] contact_force_o,
  input logic signed [rpc_pkg::FIELD_W-1:0] force_slope_o,
  input logic signed [rpc_pkg::FIELD_W-1:0] friction_limit_o,
  input logic signed [rpc_pkg::FIELD_W-1:0] gap_correction_o
);

  // Input only blocks when a finished result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked output");

  // Penalty force and its slope are never negative
  a_force_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!contact_force_o[31] && !force_slope_o[31]))
    else $error("negative contact force or slope");

  // A blocked result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(contact_force_o) && $stable(gap_correction_o)
       && $stable(friction_limit_o) && $stable(force_slope_o)))
    else $error("output changed while stalled");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind regularized_penalty_contact_law rpc_checker u_rpc_checker (.*);
